>>> hdl/gsa_pkg.sv
// Shared types and codes for the generational slot allocator.
package gsa_pkg;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_STALE   = 2'd1;
  localparam logic [1:0] STATUS_MISSING = 2'd2;
  localparam logic [1:0] STATUS_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  slot_index;
    logic [15:0] handle_version;
    logic [63:0] payload_in;
  } gsa_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  out_index;
    logic [15:0] out_version;
    logic [63:0] payload_out;
  } gsa_result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_EXEC
  } gsa_state_t;

endpackage

>>> hdl/gsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/generational_slot_allocator_top.sv
// Top level of the generational slot allocator: sequencer, counters and two RAMs.
//
// Usage: drive command and raise start; the beat is taken at a clock edge where
// start is high and busy is low. Each command yields exactly one result beat,
// shown on result for one cycle with done high. The receiver cannot stall.
// Path from accept to done, by command:
//   add with the table full, out-of-range handle, unused mode - answered from S_IDLE
//   remove, lookup (one entry RAM read), add of a never-used slot - via S_EXEC
//   add that reuses a freed slot - free stack read, entry read in S_POP, then S_EXEC
// One command is in flight at a time; busy stays high until the result is
// registered, so a new command can be taken in the cycle done is shown.
// A new command is not taken before the last one is done; a reused-slot add takes
// longest, through the chained reads of the free stack RAM and the entry RAM.
// Reset clears the free count and the issued-slot count; no RAM clearing pass
// runs, since slots at or above the issued count are never read and each
// newly issued slot is written with version 0. Commands may start on the
// first cycle after reset.
module generational_slot_allocator_top
  import gsa_pkg::*;
#(
  parameter int SLOTS        = 64,
  parameter int VERSION_BITS = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  gsa_cmd_t    command,
  output logic        done,
  output gsa_result_t result
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = 1 + VERSION_BITS + PAYLOAD_BITS;

  gsa_state_t state, state_next;
  gsa_cmd_t   cmd_q, cmd_next;
  logic [IW-1:0] slot_q, slot_next;
  logic          fresh_q, fresh_next;
  logic [CW-1:0] free_count, free_count_next;
  logic [CW-1:0] issued, issued_next;
  logic          done_next;
  gsa_result_t   result_next;

  logic          ent_we, ent_re;
  logic [IW-1:0] ent_waddr, ent_raddr;
  logic [EW-1:0] ent_wdata, ent_rdata;
  logic          stk_we, stk_re;
  logic [IW-1:0] stk_waddr, stk_raddr;
  logic [IW-1:0] stk_wdata, stk_rdata;

  logic                    rd_occ;
  logic [VERSION_BITS-1:0] rd_ver;
  logic [PAYLOAD_BITS-1:0] rd_payload;
  logic [VERSION_BITS-1:0] ver_cur;
  logic                    in_range;

  assign rd_occ     = ent_rdata[EW-1];
  assign rd_ver     = ent_rdata[PAYLOAD_BITS +: VERSION_BITS];
  assign rd_payload = ent_rdata[PAYLOAD_BITS-1:0];
  assign ver_cur    = fresh_q ? '0 : rd_ver;
  assign in_range   = 32'(command.slot_index) < 32'(issued);
  assign busy       = (state != S_IDLE);

  gsa_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  gsa_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_comb begin
    state_next      = state;
    cmd_next        = cmd_q;
    slot_next       = slot_q;
    fresh_next      = fresh_q;
    free_count_next = free_count;
    issued_next     = issued;
    done_next       = 1'b0;
    result_next     = '0;
    ent_re          = 1'b0;
    ent_raddr       = IW'(command.slot_index);
    ent_we          = 1'b0;
    ent_waddr       = slot_q;
    ent_wdata       = '0;
    stk_re          = 1'b0;
    stk_raddr       = IW'(free_count - 1'b1);
    stk_we          = 1'b0;
    stk_waddr       = IW'(free_count);
    stk_wdata       = IW'(cmd_q.slot_index);

    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_next = command;
          case (command.mode)
            MODE_ADD: begin
              if (free_count != '0) begin
                stk_re          = 1'b1;
                free_count_next = free_count - 1'b1;
                fresh_next      = 1'b0;
                state_next      = S_POP;
              end else if (issued != CW'(SLOTS)) begin
                slot_next   = IW'(issued);
                issued_next = issued + 1'b1;
                fresh_next  = 1'b1;
                state_next  = S_EXEC;
              end else begin
                done_next          = 1'b1;
                result_next.status = STATUS_FULL;
              end
            end
            MODE_REMOVE, MODE_LOOKUP: begin
              if (in_range) begin
                ent_re     = 1'b1;
                slot_next  = IW'(command.slot_index);
                fresh_next = 1'b0;
                state_next = S_EXEC;
              end else begin
                done_next          = 1'b1;
                result_next.status = STATUS_STALE;
              end
            end
            default: begin
              done_next          = 1'b1;
              result_next.status = STATUS_STALE;
            end
          endcase
        end
      end

      S_POP: begin
        ent_re     = 1'b1;
        ent_raddr  = stk_rdata;
        slot_next  = stk_rdata;
        state_next = S_EXEC;
      end

      S_EXEC: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
        case (cmd_q.mode)
          MODE_ADD: begin
            ent_we                  = 1'b1;
            ent_wdata               = {1'b1, ver_cur, PAYLOAD_BITS'(cmd_q.payload_in)};
            result_next.status      = STATUS_OK;
            result_next.out_index   = 6'(slot_q);
            result_next.out_version = 16'(ver_cur);
          end
          MODE_REMOVE, MODE_LOOKUP: begin
            if (32'(rd_ver) != 32'(cmd_q.handle_version)) begin
              result_next.status = STATUS_STALE;
            end else if (!rd_occ) begin
              result_next.status = STATUS_MISSING;
            end else begin
              result_next.status = STATUS_OK;
              if (cmd_q.mode == MODE_REMOVE) begin
                ent_we          = 1'b1;
                ent_wdata       = {1'b0, VERSION_BITS'(rd_ver + 1'b1), rd_payload};
                stk_we          = 1'b1;
                free_count_next = free_count + 1'b1;
              end else begin
                result_next.payload_out = 64'(rd_payload);
              end
            end
          end
          default: begin
            result_next.status = STATUS_STALE;
          end
        endcase
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_count <= '0;
      issued     <= '0;
      done       <= 1'b0;
      fresh_q    <= 1'b0;
    end else begin
      state      <= state_next;
      free_count <= free_count_next;
      issued     <= issued_next;
      done       <= done_next;
      fresh_q    <= fresh_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q  <= cmd_next;
    slot_q <= slot_next;
    result <= result_next;
  end

endmodule

>>> hdl/gsa_chk.sv
// Port-level checker for the generational slot allocator, bound to the top level.
module gsa_chk
  import gsa_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input gsa_result_t result
);

  logic accept;
  assign accept = start && !busy;

  a_accept_answers: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done))
    else $error("accepted beat neither kept busy nor answered");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat shown while still busy");

  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || accept))
    else $error("result beat with no command in flight");

  a_busy_bounded: assert property (@(posedge clk) disable iff (rst)
    (busy && $past(busy)) |=> !busy)
    else $error("busy held longer than two cycles");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != STATUS_OK) |->
      (result.out_index == '0 && result.out_version == '0 && result.payload_out == '0))
    else $error("failed command returned nonzero fields");

endmodule

bind generational_slot_allocator_top gsa_chk u_gsa_chk (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .result  (result)
);

>>> dv/generational_slot_allocator_top_tb.sv
// Self-checking testbench for the generational slot allocator: directed, fill and random beats.
`timescale 1ns / 100ps

module generational_slot_allocator_top_tb;
  import gsa_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned MAX_GAP = 20;
  localparam int unsigned PHASE_BEATS = 217;

  class slot_table_tracker;
    localparam int SLOT_COUNT = 64;
    logic [15:0] slot_version [SLOT_COUNT];
    bit slot_occupied [SLOT_COUNT];
    logic [63:0] slot_payload [SLOT_COUNT];
    logic [5:0] free_stack [SLOT_COUNT];
    int unsigned free_count;
    int unsigned slots_issued;
    gsa_result_t results_due [$];
    int unsigned errors;

    function new();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_version[i] = '0;
        slot_occupied[i] = 1'b0;
        slot_payload[i] = '0;
        free_stack[i] = '0;
      end
      free_count = 0;
      slots_issued = 0;
      errors = 0;
    endfunction

    function logic [1:0] handle_status(logic [5:0] idx, logic [15:0] ver);
      if (idx >= slots_issued || slot_version[idx] != ver) return STATUS_STALE;
      if (!slot_occupied[idx]) return STATUS_MISSING;
      return STATUS_OK;
    endfunction

    function void note_command(gsa_cmd_t c);
      gsa_result_t r;
      int unsigned slot;
      r = '0;
      r.status = STATUS_OK;
      case (c.mode)
        MODE_ADD: begin
          if (free_count > 0) begin
            free_count--;
            slot = free_stack[free_count];
          end else if (slots_issued < SLOT_COUNT) begin
            slot = slots_issued;
            slots_issued++;
            slot_version[slot] = '0;
          end else begin
            slot = SLOT_COUNT;
          end
          if (slot < SLOT_COUNT) begin
            slot_payload[slot] = c.payload_in;
            slot_occupied[slot] = 1'b1;
            r.out_index = 6'(slot);
            r.out_version = slot_version[slot];
          end else begin
            r.status = STATUS_FULL;
          end
        end
        MODE_REMOVE: begin
          r.status = handle_status(c.slot_index, c.handle_version);
          if (r.status == STATUS_OK) begin
            slot_occupied[c.slot_index] = 1'b0;
            slot_payload[c.slot_index] = '0;
            slot_version[c.slot_index] = slot_version[c.slot_index] + 16'd1;
            free_stack[free_count] = c.slot_index;
            free_count++;
          end
        end
        MODE_LOOKUP: begin
          r.status = handle_status(c.slot_index, c.handle_version);
          if (r.status == STATUS_OK) r.payload_out = slot_payload[c.slot_index];
        end
        default: r.status = STATUS_STALE;
      endcase
      results_due = {results_due, r};
    endfunction

    function void check_result(gsa_result_t r);
      gsa_result_t e;
      if (results_due.size() == 0) begin
        $error("result beat with no command outstanding");
        errors++;
        return;
      end
      e = results_due.pop_front();
      if (r.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, r.status);
        errors++;
      end
      if (r.out_index !== e.out_index) begin
        $error("out_index expected %0d actual %0d", e.out_index, r.out_index);
        errors++;
      end
      if (r.out_version !== e.out_version) begin
        $error("out_version expected %0h actual %0h", e.out_version, r.out_version);
        errors++;
      end
      if (r.payload_out !== e.payload_out) begin
        $error("payload_out expected %0h actual %0h", e.payload_out, r.payload_out);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  gsa_cmd_t command = '0;
  gsa_result_t result;

  slot_table_tracker sb = new();
  int unsigned accepted_beats = 0;
  int unsigned cycle_count = 0;

  generational_slot_allocator_top uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .done(done),
    .result(result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(result);
      if (start && !busy) begin
        sb.note_command(command);
        accepted_beats++;
      end
    end
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic gsa_cmd_t make_command(logic [1:0] mode, logic [5:0] idx,
                                            logic [15:0] ver, logic [63:0] data);
    gsa_cmd_t c;
    c.mode = mode;
    c.slot_index = idx;
    c.handle_version = ver;
    c.payload_in = data;
    return c;
  endfunction

  function automatic int unsigned idle_gap(int unsigned pct);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < pct) gap++;
    return gap;
  endfunction

  function automatic gsa_cmd_t pick_command(int unsigned add_weight);
    gsa_cmd_t c;
    int unsigned roll;
    int unsigned idx;
    int unsigned twist;
    c.payload_in = {$urandom, $urandom};
    c.slot_index = 6'($urandom_range(63));
    c.handle_version = 16'($urandom);
    roll = $urandom_range(99);
    if (roll < add_weight) begin
      c.mode = MODE_ADD;
    end else if (roll >= 95) begin
      c.mode = 2'($urandom_range(3));
    end else begin
      c.mode = ($urandom_range(1) == 1) ? MODE_REMOVE : MODE_LOOKUP;
      if (sb.slots_issued != 0 && $urandom_range(9) != 0) begin
        idx = $urandom_range(sb.slots_issued - 1);
        c.slot_index = 6'(idx);
        twist = $urandom_range(9);
        if (twist == 0) c.handle_version = sb.slot_version[idx] + 16'd1;
        else if (twist == 1) c.handle_version = sb.slot_version[idx] - 16'd1;
        else c.handle_version = sb.slot_version[idx];
      end
    end
    return c;
  endfunction

  task automatic send_beat(gsa_cmd_t c, int unsigned gap);
    int unsigned seen;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    seen = accepted_beats;
    start <= 1'b1;
    command <= c;
    do @(negedge clk); while (accepted_beats == seen);
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    while (sb.results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int unsigned pct [4];
    int unsigned add_weight [4];
    pct = '{0, 74, 0, 15};
    add_weight = '{45, 60, 30, 50};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_beat(make_command(MODE_LOOKUP, 6'd0, 16'd0, '0), 0);
    send_beat(make_command(MODE_REMOVE, 6'd63, 16'hFFFF, '1), 0);
    send_beat(make_command(MODE_UNUSED, 6'd63, 16'hFFFF, '1), 0);
    send_beat(make_command(MODE_ADD, 6'd63, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF), 0);
    send_beat(make_command(MODE_ADD, 6'd0, 16'd0, 64'h0), 0);
    send_beat(make_command(MODE_LOOKUP, 6'd0, 16'd0, '0), 0);
    send_beat(make_command(MODE_LOOKUP, 6'd1, 16'd0, '0), 1);
    send_beat(make_command(MODE_LOOKUP, 6'd0, 16'hFFFF, '0), 0);
    send_beat(make_command(MODE_LOOKUP, 6'd2, 16'd0, '0), 2);
    send_beat(make_command(MODE_REMOVE, 6'd0, 16'd0, '0), 0);
    send_beat(make_command(MODE_REMOVE, 6'd0, 16'd1, '0), 0);
    send_beat(make_command(MODE_LOOKUP, 6'd0, 16'd1, '0), 0);
    send_beat(make_command(MODE_LOOKUP, 6'd0, 16'd0, '0), 0);
    send_beat(make_command(MODE_ADD, 6'd0, 16'd0, 64'hAAAA_AAAA_AAAA_AAAA), 0);
    send_beat(make_command(MODE_LOOKUP, 6'd0, 16'd1, '0), 3);
    send_beat(make_command(MODE_ADD, 6'd0, 16'd0, 64'h5555_5555_5555_5555), 0);
    send_beat(make_command(MODE_REMOVE, 6'd2, 16'd0, '0), 0);
    send_beat(make_command(MODE_ADD, 6'd0, 16'd0, 64'h8000_0000_0000_0001), 0);
    hold_until_drained();

    while (sb.free_count != 0 || sb.slots_issued != 64)
      send_beat(make_command(MODE_ADD, 6'd0, 16'd0, {$urandom, $urandom}), idle_gap(15));
    send_beat(make_command(MODE_ADD, 6'd0, 16'd0, '1), 0);
    send_beat(make_command(MODE_LOOKUP, 6'd63, 16'd0, '0), 0);
    send_beat(make_command(MODE_ADD, 6'd0, 16'd0, '0), 0);
    hold_until_drained();

    for (int p = 0; p < 4; p++) begin
      for (int n = 0; n < PHASE_BEATS; n++)
        send_beat(pick_command(add_weight[p]), idle_gap(pct[p]));
      hold_until_drained();
    end

    if (sb.errors == 0 && sb.results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/gsa_pkg.sv
hdl/gsa_ram.sv
hdl/generational_slot_allocator_top.sv
hdl/gsa_chk.sv
dv/generational_slot_allocator_top_tb.sv
